### src/rhs_pkg.sv
// ----------------------------------------------------------------------------
// rhs_pkg: shared types and constants for the record header scanner
// Holds the transaction and result structs, scan phase codes and status codes.
// ----------------------------------------------------------------------------
package rhs_pkg;

    localparam int EVT_HDR_BYTES = 16;
    localparam int REC_HDR_BYTES = 8;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] ST_NOT_FOUND = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_EVHDR  = 4'b0010,
        PH_RECHDR = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic [15:0] want_group;
        logic [7:0]  want_item;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] position;
        logic [30:0] length;
        logic [7:0]  record_type;
    } result_t;

endpackage

### src/rhs_in_stage.sv
// ----------------------------------------------------------------------------
// rhs_in_stage: input register
// Captures one input transaction and holds it until the scan core takes it.
// ----------------------------------------------------------------------------
module rhs_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rhs_pkg::item_t  s_item,
    input  logic            take,
    output logic            item_valid,
    output rhs_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    rhs_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

### src/rhs_scan_core.sv
// ----------------------------------------------------------------------------
// rhs_scan_core: record scan state and per-byte step
// Tracks the event header, record headers and skipped payload, and decides
// found, not found or malformed for the current scan.
// ----------------------------------------------------------------------------
module rhs_scan_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  rhs_pkg::item_t    item,
    output logic              res_valid,
    output rhs_pkg::result_t  res
);

    rhs_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     byte_offset_reg, byte_offset_next;
    logic [31:0]     event_size_reg, event_size_next;
    logic [63:0]     header_reg, header_next;
    logic [30:0]     skip_left_reg, skip_left_next;
    logic [2:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]     target_group_reg, target_group_next;
    logic [7:0]      target_item_reg, target_item_next;

    logic [31:0] rec_len;
    logic [33:0] rec_end;

    // length field once the last header byte is shifted in
    assign rec_len = {item.data_byte, header_reg[63:40]};
    assign rec_end = {2'b00, byte_offset_reg} + {2'b00, rec_len}
                   + 34'(rhs_pkg::REC_HDR_BYTES + 1);

    always_comb begin
        phase_next        = phase_reg;
        byte_offset_next  = byte_offset_reg;
        event_size_next   = event_size_reg;
        header_next       = header_reg;
        skip_left_next    = skip_left_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        target_group_next = target_group_reg;
        target_item_next  = target_item_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (item.op == rhs_pkg::OP_DATA) begin
            header_next = {item.data_byte, header_reg[63:8]};
        end
        byte_offset_next = byte_offset_reg + 32'd1;

        if (item.op == rhs_pkg::OP_QUERY) begin
            target_group_next = item.want_group;
            target_item_next  = item.want_item;
            byte_offset_next  = '0;
            event_size_next   = '0;
            skip_left_next    = '0;
            hdr_cnt_next      = '0;
            phase_next        = rhs_pkg::PH_EVHDR;
        end else begin
            unique case (phase_reg)
                rhs_pkg::PH_EVHDR: begin
                    if (byte_offset_reg[3:2] == 2'b01) begin
                        event_size_next[{byte_offset_reg[1:0], 3'b000} +: 8] = item.data_byte;
                    end
                    if (byte_offset_reg == 32'(rhs_pkg::EVT_HDR_BYTES - 1)) begin
                        // first record header would start at the end of the event header
                        if (32'(rhs_pkg::EVT_HDR_BYTES + rhs_pkg::REC_HDR_BYTES)
                                >= event_size_next) begin
                            res_valid  = 1'b1;
                            res.status = rhs_pkg::ST_NOT_FOUND;
                            phase_next = rhs_pkg::PH_IDLE;
                        end else begin
                            hdr_cnt_next = '0;
                            phase_next   = rhs_pkg::PH_RECHDR;
                        end
                    end
                end
                rhs_pkg::PH_RECHDR: begin
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_reg == 3'(rhs_pkg::REC_HDR_BYTES - 1)) begin
                        priority if (rec_len[31]) begin
                            res_valid    = 1'b1;
                            res.status   = rhs_pkg::ST_MALFORMED;
                            res.position = byte_offset_reg - 32'(rhs_pkg::REC_HDR_BYTES - 1);
                            phase_next   = rhs_pkg::PH_IDLE;
                        end else if (header_next[15:0] == target_group_reg
                                     && header_next[23:16] == target_item_reg) begin
                            res_valid       = 1'b1;
                            res.status      = rhs_pkg::ST_FOUND;
                            res.position    = byte_offset_reg
                                            - 32'(rhs_pkg::REC_HDR_BYTES - 1);
                            res.length      = rec_len[30:0];
                            res.record_type = header_next[31:24];
                            phase_next      = rhs_pkg::PH_IDLE;
                        end else if (rec_end >= {2'b00, event_size_reg}) begin
                            res_valid  = 1'b1;
                            res.status = rhs_pkg::ST_NOT_FOUND;
                            phase_next = rhs_pkg::PH_IDLE;
                        end else if (rec_len == 32'd0) begin
                            hdr_cnt_next = '0;
                            phase_next   = rhs_pkg::PH_RECHDR;
                        end else begin
                            skip_left_next = rec_len[30:0];
                            phase_next     = rhs_pkg::PH_SKIP;
                        end
                    end
                end
                rhs_pkg::PH_SKIP: begin
                    skip_left_next = skip_left_reg - 31'd1;
                    if (skip_left_reg == 31'd1) begin
                        hdr_cnt_next = '0;
                        phase_next   = rhs_pkg::PH_RECHDR;
                    end
                end
                rhs_pkg::PH_IDLE: begin
                    byte_offset_next = byte_offset_reg;
                end
                default: begin
                    byte_offset_next = byte_offset_reg;
                    phase_next       = rhs_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= rhs_pkg::PH_IDLE;
            byte_offset_reg  <= '0;
            event_size_reg   <= '0;
            skip_left_reg    <= '0;
            hdr_cnt_reg      <= '0;
            target_group_reg <= '0;
            target_item_reg  <= '0;
        end else if (fire) begin
            phase_reg        <= phase_next;
            byte_offset_reg  <= byte_offset_next;
            event_size_reg   <= event_size_next;
            skip_left_reg    <= skip_left_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            target_group_reg <= target_group_next;
            target_item_reg  <= target_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            header_reg <= header_next;
        end
    end

endmodule

### src/rhs_out_stage.sv
// ----------------------------------------------------------------------------
// rhs_out_stage: result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module rhs_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  rhs_pkg::result_t  res,
    output logic              m_valid,
    input  logic              m_ready,
    output rhs_pkg::result_t  m_res,
    output logic              free
);

    logic             valid_reg;
    logic             valid_next;
    rhs_pkg::result_t res_reg;

    assign m_valid = valid_reg;
    assign m_res   = res_reg;
    assign free    = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

### src/record_header_scan.sv
// ----------------------------------------------------------------------------
// record_header_scan: streamed event record search
// Scans event bytes for a record header with a wanted group and item.
// ----------------------------------------------------------------------------
//   channel | direction | fields
//   s_      | in        | op, data_byte, want_group, want_item
//   m_      | out       | status, position, length, record_type
//
// one transaction per cycle unless the result register stalls; a transaction
// passes the input register, then the scan step loads the result register
// the scan step compares a 34-bit record end sum with the event size
// synchronous active-low reset returns the scan to idle with no result pending
// a stalled result holds the scan step; the input register keeps one more
// transaction, then s_ready drops
// ----------------------------------------------------------------------------
module record_header_scan (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_want_group,
    input  logic [7:0]  s_want_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_position,
    output logic [30:0] m_length,
    output logic [7:0]  m_record_type
);

    rhs_pkg::item_t   s_item;
    rhs_pkg::item_t   item;
    rhs_pkg::result_t res;
    rhs_pkg::result_t m_res;
    logic             item_valid;
    logic             res_valid;
    logic             out_free;
    logic             fire;

    assign s_item.op         = s_op;
    assign s_item.data_byte  = s_data_byte;
    assign s_item.want_group = s_want_group;
    assign s_item.want_item  = s_want_item;

    assign fire = item_valid && out_free;

    rhs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    rhs_scan_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    rhs_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire && res_valid),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res),
        .free    (out_free)
    );

    assign m_status      = m_res.status;
    assign m_position    = m_res.position;
    assign m_length      = m_res.length;
    assign m_record_type = m_res.record_type;

endmodule

### src/rhs_checker.sv
// ----------------------------------------------------------------------------
// rhs_checker: port-level checks for the record header scanner
// Watches the result channel and the status coding of result transactions.
// ----------------------------------------------------------------------------
module rhs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_position,
    input logic [30:0] m_length,
    input logic [7:0]  m_record_type
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_position)
            && $stable(m_length) && $stable(m_record_type))
        else $error("result transaction changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == rhs_pkg::ST_NOT_FOUND || m_status == rhs_pkg::ST_FOUND
            || m_status == rhs_pkg::ST_MALFORMED)
        else $error("unknown status code");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rhs_pkg::ST_NOT_FOUND
            |-> m_position == 32'd0 && m_length == 31'd0 && m_record_type == 8'd0)
        else $error("not found result carries record fields");

    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rhs_pkg::ST_MALFORMED
            |-> m_length == 31'd0 && m_record_type == 8'd0)
        else $error("malformed result carries length or type");

endmodule

bind record_header_scan rhs_checker u_rhs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_position    (m_position),
    .m_length      (m_length),
    .m_record_type (m_record_type)
);

### dv/record_header_scan_tb.sv
// ----------------------------------------------------------------------------
// record_header_scan_tb: self-checking bench for the record header scanner
// Sends queries and event byte streams, predicts each scan outcome with a
// shadow scanner or a pinned drill row, compares every result field by field.
// ----------------------------------------------------------------------------
module record_header_scan_tb;
    import rhs_pkg::*;

    localparam int RAND_ITEMS  = 1200;
    localparam int STALL_LIMIT = 4000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_op          = OP_QUERY;
    logic [7:0]  s_data_byte   = '0;
    logic [15:0] s_want_group  = '0;
    logic [7:0]  s_want_item   = '0;
    logic        m_ready       = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [1:0]  m_status;
    logic [31:0] m_position;
    logic [30:0] m_length;
    logic [7:0]  m_record_type;

    // shadow scanner state
    phase_t      sh_phase  = PH_IDLE;
    logic [31:0] sh_offset = '0;
    logic [31:0] sh_size   = '0;
    logic [63:0] sh_hdr    = '0;
    logic [31:0] sh_count  = '0;
    logic [15:0] sh_group  = '0;
    logic [7:0]  sh_item   = '0;

    result_t search_outcomes[$];

    typedef struct {
        logic        op;
        logic [7:0]  dbyte;
        logic [15:0] grp;
        logic [7:0]  itm;
        int          reps;
        bit          pin;
        result_t     res;
    } drill_row_t;

    drill_row_t drill[$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int n_items = 0;
    int n_results = 0;
    int n_found = 0;
    int n_absent = 0;
    int n_malformed = 0;
    int errors = 0;
    int quiet_cycles = 0;

    record_header_scan i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_data_byte   (s_data_byte),
        .s_want_group  (s_want_group),
        .s_want_item   (s_want_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_position    (m_position),
        .m_length      (m_length),
        .m_record_type (m_record_type)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit close_scan(input logic [1:0] st, input logic [31:0] pos,
            input logic [30:0] len, input logic [7:0] typ, output result_t res);
        res.status      = st;
        res.position    = pos;
        res.length      = len;
        res.record_type = typ;
        sh_phase        = PH_IDLE;
        return 1'b1;
    endfunction

    function automatic bit search_step(input item_t it, output result_t res);
        logic [31:0] rec_len;
        logic [31:0] rec_pos;
        bit          done;
        res  = '0;
        done = 1'b0;
        if (it.op == OP_QUERY) begin
            sh_group  = it.want_group;
            sh_item   = it.want_item;
            sh_offset = '0;
            sh_size   = '0;
            sh_hdr    = '0;
            sh_count  = '0;
            sh_phase  = PH_EVHDR;
        end else begin
            case (sh_phase)
                PH_EVHDR: begin
                    if (sh_offset >= 4 && sh_offset < 8)
                        sh_size[8*sh_offset[1:0] +: 8] = it.data_byte;
                    sh_offset++;
                    if (sh_offset >= EVT_HDR_BYTES) begin
                        if (64'(sh_offset) + REC_HDR_BYTES >= 64'(sh_size)) begin
                            done = close_scan(ST_NOT_FOUND, '0, '0, '0, res);
                        end else begin
                            sh_phase = PH_RECHDR;
                            sh_count = '0;
                            sh_hdr   = '0;
                        end
                    end
                end
                PH_RECHDR: begin
                    sh_hdr = {it.data_byte, sh_hdr[63:8]};
                    sh_offset++;
                    sh_count++;
                    if (sh_count >= REC_HDR_BYTES) begin
                        rec_pos = sh_offset - REC_HDR_BYTES;
                        rec_len = sh_hdr[63:32];
                        if (rec_len[31]) begin
                            done = close_scan(ST_MALFORMED, rec_pos, '0, '0, res);
                        end else if (sh_hdr[15:0] == sh_group && sh_hdr[23:16] == sh_item) begin
                            done = close_scan(ST_FOUND, rec_pos, rec_len[30:0], sh_hdr[31:24],
                                              res);
                        end else if (64'(sh_offset) + 64'(rec_len) + REC_HDR_BYTES
                                     >= 64'(sh_size)) begin
                            done = close_scan(ST_NOT_FOUND, '0, '0, '0, res);
                        end else if (rec_len == 0) begin
                            sh_count = '0;
                            sh_hdr   = '0;
                        end else begin
                            sh_phase = PH_SKIP;
                            sh_count = rec_len;
                        end
                    end
                end
                PH_SKIP: begin
                    sh_offset++;
                    if (sh_count != 0)
                        sh_count--;
                    if (sh_count == 0) begin
                        sh_phase = PH_RECHDR;
                        sh_hdr   = '0;
                    end
                end
                default: ;
            endcase
        end
        return done;
    endfunction

    function automatic void drill_add(input logic op, input logic [7:0] dbyte,
            input logic [15:0] grp, input logic [7:0] itm, input int reps,
            input bit pin = 1'b0, input result_t res = '0);
        drill_row_t row;
        row.op    = op;
        row.dbyte = dbyte;
        row.grp   = grp;
        row.itm   = itm;
        row.reps  = reps;
        row.pin   = pin;
        row.res   = res;
        drill.insert(drill.size(), row);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] dbyte, input logic [15:0] grp,
            input logic [7:0] itm, input bit pin = 1'b0, input result_t pin_res = '0);
        item_t   it;
        result_t res;
        it.op         = op;
        it.data_byte  = dbyte;
        it.want_group = grp;
        it.want_item  = itm;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= it.op;
        s_data_byte  <= it.data_byte;
        s_want_group <= it.want_group;
        s_want_item  <= it.want_item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        n_items++;
        if (search_step(it, res) || pin)
            search_outcomes.insert(search_outcomes.size(), pin ? pin_res : res);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (search_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    // one query followed by a mostly well-formed event, sometimes cut short
    task automatic send_event();
        logic [15:0]     grp;
        logic [7:0]      itm;
        logic [7:0]      evt[$];
        logic [31:0]     rec_len;
        logic [31:0]     evt_bytes;
        longint unsigned span;
        int              nrec;
        int              pick;
        int              npay;
        int              keep;
        bit              stop;
        grp  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
        itm  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        span = EVT_HDR_BYTES;
        nrec = $urandom_range(0, 4);
        stop = 1'b0;
        for (int r = 0; r < nrec && !stop; r++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                rec_len = $urandom_range(0, 6);
            end else if (pick < 75) begin
                rec_len = '0;
            end else if (pick < 88) begin
                rec_len = $urandom & 32'h7FFF_FFFF;
                stop    = 1'b1;
            end else begin
                rec_len = $urandom | 32'h8000_0000;
                stop    = 1'b1;
            end
            evt.insert(evt.size(),
                       ($urandom_range(0, 2) == 0) ? grp[7:0] : 8'($urandom_range(0, 2)));
            evt.insert(evt.size(),
                       ($urandom_range(0, 2) == 0) ? grp[15:8] : 8'($urandom_range(0, 1)));
            evt.insert(evt.size(),
                       ($urandom_range(0, 2) == 0) ? itm : 8'($urandom_range(0, 2)));
            evt.insert(evt.size(), 8'($urandom));
            for (int k = 0; k < 4; k++)
                evt.insert(evt.size(), rec_len[8*k +: 8]);
            npay = stop ? $urandom_range(0, 6) : int'(rec_len);
            repeat (npay)
                evt.insert(evt.size(), 8'($urandom));
            span += REC_HDR_BYTES + rec_len;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
            evt_bytes = 32'(span);
        else if (pick < 70)
            evt_bytes = 32'(span) + $urandom_range(1, 40);
        else if (pick < 85)
            evt_bytes = $urandom_range(0, 40);
        else
            evt_bytes = $urandom;
        for (int k = EVT_HDR_BYTES - 1; k >= 0; k--)
            evt.push_front((k >= 4 && k < 8) ? evt_bytes[8*(k-4) +: 8] : 8'($urandom));
        // trailing bytes beyond the records
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 4))
                evt.insert(evt.size(), 8'($urandom));
        keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, evt.size()) : evt.size();
        send_item(OP_QUERY, 8'($urandom), grp, itm);
        for (int k = 0; k < keep; k++)
            send_item(OP_DATA, evt[k], 16'($urandom), 8'($urandom));
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            case (m_status)
                ST_FOUND:     n_found++;
                ST_MALFORMED: n_malformed++;
                default:      n_absent++;
            endcase
            if (search_outcomes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction: status %0d position %0d",
                             m_status, m_position);
            end else begin
                want = search_outcomes.pop_front();
                if (want.status !== m_status || want.position !== m_position
                        || want.length !== m_length || want.record_type !== m_record_type) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected st %0d pos %0d len %0h type %0h, ",
                                  "got st %0d pos %0d len %0h type %0h"},
                                 want.status, want.position, want.length, want.record_type,
                                 m_status, m_position, m_length, m_record_type);
                end
            end
        end
    end

    initial begin : watchdog
        @(posedge aresetn);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("FAIL record_header_scan");
        $finish;
    end

    initial begin : stimulus
        int dir_items;
        int mix;
        int next_mix;

        // malformed length wins over a matching group and item
        drill_add(OP_DATA,  8'hFF, 16'h0000, 8'h00, 1);
        drill_add(OP_QUERY, 8'h00, 16'hFFFF, 8'hFF, 1);
        drill_add(OP_DATA,  8'h5A, 16'h0000, 8'h00, 1);
        drill_add(OP_QUERY, 8'hFF, 16'h0000, 8'h00, 1);
        drill_add(OP_DATA,  8'h00, 16'h0000, 8'h00, 4);
        drill_add(OP_DATA,  8'h20, 16'h0000, 8'h00, 1);
        drill_add(OP_DATA,  8'h00, 16'h0000, 8'h00, 3);
        drill_add(OP_DATA,  8'hFF, 16'h0000, 8'h00, 8);
        drill_add(OP_DATA,  8'h00, 16'h0000, 8'h00, 7);
        drill_add(OP_DATA,  8'h80, 16'h0000, 8'h00, 1, 1'b1,
                  result_t'{ST_MALFORMED, 32'd16, 31'd0, 8'd0});
        drill_add(OP_DATA,  8'h3C, 16'h0000, 8'h00, 1);
        // match at the first record with the largest legal length
        drill_add(OP_QUERY, 8'h00, 16'hFFFF, 8'hFF, 1);
        drill_add(OP_DATA,  8'h00, 16'hFFFF, 8'hFF, 4);
        drill_add(OP_DATA,  8'hFF, 16'hFFFF, 8'hFF, 4);
        drill_add(OP_DATA,  8'h00, 16'hFFFF, 8'hFF, 8);
        drill_add(OP_DATA,  8'hFF, 16'hFFFF, 8'hFF, 3);
        drill_add(OP_DATA,  8'h7F, 16'hFFFF, 8'hFF, 1);
        drill_add(OP_DATA,  8'hFF, 16'hFFFF, 8'hFF, 3);
        drill_add(OP_DATA,  8'h7F, 16'hFFFF, 8'hFF, 1, 1'b1,
                  result_t'{ST_FOUND, 32'd16, 31'h7FFF_FFFF, 8'h7F});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (drill[r])
            repeat (drill[r].reps)
                send_item(drill[r].op, drill[r].dbyte, drill[r].grp, drill[r].itm,
                          drill[r].pin, drill[r].res);
        hold_until_drained();

        dir_items = n_items;
        mix       = 0;
        while (n_items < dir_items + RAND_ITEMS) begin
            next_mix = (n_items - dir_items) * 4 / RAND_ITEMS;
            if (next_mix != mix) begin
                hold_until_drained();
                mix = next_mix;
                case (mix)
                    1:       begin src_idle_pct = 78; snk_stall_pct = 0;  end
                    2:       begin src_idle_pct = 0;  snk_stall_pct = 78; end
                    default: begin src_idle_pct = 6;  snk_stall_pct = 6;  end
                endcase
            end
            if ($urandom_range(0, 99) < 6)
                send_item(1'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
            else
                send_event();
        end

        hold_until_drained();
        repeat (12) @(posedge aclk);

        $display("covered %0d transactions in, %0d results out",
                 n_items, n_results);
        $display("(%0d found, %0d not found, %0d malformed); %0d mismatches",
                 n_found, n_absent, n_malformed, errors);
        if (errors == 0 && search_outcomes.size() == 0)
            $display("PASS record_header_scan");
        else
            $display("FAIL record_header_scan");
        $finish;
    end

endmodule

### files.f
src/rhs_pkg.sv
src/rhs_in_stage.sv
src/rhs_scan_core.sv
src/rhs_out_stage.sv
src/record_header_scan.sv
src/rhs_checker.sv
dv/record_header_scan_tb.sv
